// ===== src/dsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types, character codes and helpers for the date string field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfp_pkg;

    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int ORDER_BITS  = 2;
    localparam int RESULT_BITS = 17;
    localparam int SPLIT_BITS  = 14;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ORDER_FIRST  = 2'd0;
    localparam logic [1:0] REG_ORDER_SECOND = 2'd1;
    localparam logic [1:0] REG_ORDER_THIRD  = 2'd2;

    // field meaning codes
    localparam logic [ORDER_BITS-1:0] ORD_YEAR  = 2'd1;
    localparam logic [ORDER_BITS-1:0] ORD_MONTH = 2'd2;
    localparam logic [ORDER_BITS-1:0] ORD_DAY   = 2'd3;

    localparam logic [ORDER_BITS-1:0] ORDER_FIRST_RESET  = ORD_MONTH;
    localparam logic [ORDER_BITS-1:0] ORDER_SECOND_RESET = ORD_DAY;
    localparam logic [ORDER_BITS-1:0] ORDER_THIRD_RESET  = ORD_YEAR;

    // field positions
    localparam logic [1:0] LAST_FIELD  = 2'd2;
    localparam logic [1:0] FIELD_COUNT = 2'd3;
    localparam logic [1:0] PREFIX_FULL = 2'd3;
    localparam logic [3:0] LENGTH_MAX  = 4'd15;
    localparam logic [3:0] LENGTH_PAD  = 4'd7;

    // character codes
    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_SPACE   = " ";
    localparam logic [7:0] CH_DASH    = "-";
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_COMMA   = ",";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam int WORD_LETTER_COUNT = 23;
    localparam logic [8*WORD_LETTER_COUNT-1:0] WORD_LETTERS = "januaryfebmrchpilgstovd";

    localparam logic [11:0][23:0] MONTH_NAMES = {
        "dec", "nov", "oct", "sep", "aug", "jul",
        "jun", "may", "apr", "mar", "feb", "jan"
    };

    typedef enum logic [4:0] {
        PH_LEAD = 5'b00001,
        PH_POST = 5'b00010,
        PH_NUM  = 5'b00100,
        PH_NAME = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0]       field_index;
        phase_t           phase;
        logic [14:0]      name_prefix;
        logic [1:0]       prefix_count;
        logic [7:0][3:0]  digits;
        logic [3:0]       string_length;
        logic             all_digits;
        logic             trailing_text;
        logic [2:0]       field_name;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        field_index:   2'd0,
        phase:         PH_LEAD,
        name_prefix:   15'd0,
        prefix_count:  2'd0,
        digits:        '0,
        string_length: 4'd0,
        all_digits:    1'b1,
        trailing_text: 1'b0,
        field_name:    3'd0
    };

    function automatic logic is_word_letter(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < WORD_LETTER_COUNT; i++) begin
            if (WORD_LETTERS[8*i +: 8] == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [3:0] month_number(input logic [14:0] prefix,
                                                input logic [1:0]  count);
        logic [3:0]  num;
        logic [23:0] name;
        num = 4'd0;
        for (int i = 0; i < 12; i++) begin
            name = MONTH_NAMES[i];
            if (count == PREFIX_FULL &&
                {name[20:16], name[12:8], name[4:0]} == prefix) begin
                num = 4'(i + 1);
            end
        end
        return num;
    endfunction

    function automatic logic [6:0] dec2(input logic [3:0] a, input logic [3:0] b);
        return 7'(a) * 7'd10 + 7'(b);
    endfunction

    function automatic logic [SPLIT_BITS-1:0] dec4(input logic [3:0] a, input logic [3:0] b,
                                                   input logic [3:0] c, input logic [3:0] d);
        return SPLIT_BITS'(dec2(a, b)) * SPLIT_BITS'(100) + SPLIT_BITS'(dec2(c, d));
    endfunction

endpackage

`default_nettype wire

// ===== src/dsfp_scan.sv =====
// ----------------------------------------------------------------------------
// dsfp_scan
// Per-character field scanner: folds case, classifies the byte and advances
// the field, name and digit state by one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_scan #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           advance,
    input  wire logic                           clear,
    input  wire logic [7:0]                     char_code,
    output dsfp_pkg::scan_state_t               state,
    output logic [2:0][VALUE_BITS-1:0]          field_mag
);
    import dsfp_pkg::*;

    scan_state_t                 state_reg;
    scan_state_t                 state_next;
    logic [2:0][VALUE_BITS-1:0]  mag_reg;
    logic [2:0][VALUE_BITS-1:0]  mag_next;

    logic [7:0]             c;
    logic                   is_sp;
    logic                   is_dg;
    logic                   is_wl;
    logic                   is_sep;
    logic [3:0]             digit;
    logic [1:0]             idx;
    logic [VALUE_BITS-1:0]  cur_mag;
    logic [VALUE_BITS+3:0]  acc_wide;
    logic [3:0]             word_month;
    logic                   entry;
    logic [1:0]             entry_idx;
    logic                   close;
    logic                   acc_wr;
    logic [VALUE_BITS-1:0]  acc_val;
    logic                   acc_name;

    always_comb begin
        c = char_code;
        if (char_code inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            c = char_code | CASE_BIT;
        end
        is_sp  = (c == CH_SPACE);
        is_dg  = c inside {[CH_ZERO:CH_NINE]};
        is_wl  = is_word_letter(c);
        is_sep = c inside {CH_DASH, CH_SLASH, CH_COMMA};
        digit  = c[3:0];
        idx    = state_reg.field_index;

        cur_mag  = mag_reg[idx];
        acc_wide = ({4'd0, cur_mag} << 3) + ({4'd0, cur_mag} << 1)
                 + (VALUE_BITS + 4)'(digit);
        word_month = month_number(state_reg.name_prefix, state_reg.prefix_count);

        state_next = state_reg;
        mag_next   = mag_reg;
        entry      = 1'b0;
        entry_idx  = idx;
        close      = 1'b0;
        acc_wr     = 1'b0;
        acc_val    = '0;
        acc_name   = 1'b0;

        if (clear) begin
            state_next = SCAN_CLEAR;
            mag_next   = '0;
        end else if (advance) begin
            if (state_reg.string_length != LENGTH_MAX) begin
                state_next.string_length = state_reg.string_length + 4'd1;
            end
            if (is_dg) begin
                if (!state_reg.string_length[3]) begin
                    state_next.digits[state_reg.string_length[2:0]] = digit;
                end
            end else begin
                state_next.all_digits = 1'b0;
            end

            case (state_reg.phase)
                PH_LEAD: begin
                    entry = !is_sp;
                end
                PH_POST: begin
                    if (is_dg || is_wl) begin
                        entry = 1'b1;
                    end else if (is_sep && idx != LAST_FIELD) begin
                        state_next.field_index = idx + 2'd1;
                    end else if (!is_sp) begin
                        state_next.field_index   = FIELD_COUNT;
                        state_next.phase         = PH_DONE;
                        state_next.trailing_text = 1'b1;
                    end
                end
                PH_NUM: begin
                    if (is_dg) begin
                        acc_wr  = 1'b1;
                        acc_val = (acc_wide[VALUE_BITS+3:VALUE_BITS] != 4'd0)
                                ? {VALUE_BITS{1'b1}} : acc_wide[VALUE_BITS-1:0];
                    end else begin
                        close = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (is_wl) begin
                        if (state_reg.prefix_count != PREFIX_FULL) begin
                            state_next.name_prefix  = {state_reg.name_prefix[9:0], c[4:0]};
                            state_next.prefix_count = state_reg.prefix_count + 2'd1;
                        end
                    end else begin
                        acc_wr   = 1'b1;
                        acc_val  = VALUE_BITS'(word_month);
                        acc_name = (word_month != 4'd0);
                        close    = 1'b1;
                    end
                end
                PH_DONE: begin
                    state_next.trailing_text = 1'b1;
                end
                default: begin
                    state_next.phase = state_reg.phase;
                end
            endcase

            if (acc_wr) begin
                mag_next[idx]              = acc_val;
                state_next.field_name[idx] = acc_name;
            end

            if (close) begin
                if (idx == LAST_FIELD) begin
                    state_next.field_index   = FIELD_COUNT;
                    state_next.phase         = PH_DONE;
                    state_next.trailing_text = 1'b1;
                end else begin
                    state_next.field_index = idx + 2'd1;
                    if (is_sp) begin
                        state_next.phase = PH_LEAD;
                    end else begin
                        entry     = 1'b1;
                        entry_idx = idx + 2'd1;
                    end
                end
            end

            if (entry) begin
                if (is_sep) begin
                    state_next.field_index = (entry_idx == 2'd0) ? 2'd1 : entry_idx;
                    state_next.phase       = PH_POST;
                end else if (is_dg) begin
                    state_next.field_index           = entry_idx;
                    state_next.phase                 = PH_NUM;
                    mag_next[entry_idx]              = VALUE_BITS'(digit);
                    state_next.field_name[entry_idx] = 1'b0;
                end else if (is_wl) begin
                    state_next.field_index  = entry_idx;
                    state_next.phase        = PH_NAME;
                    state_next.name_prefix  = 15'(c[4:0]);
                    state_next.prefix_count = 2'd1;
                end else begin
                    state_next.field_index   = FIELD_COUNT;
                    state_next.phase         = PH_DONE;
                    state_next.trailing_text = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_CLEAR;
            mag_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mag_reg   <= mag_next;
        end
    end

    assign state     = state_reg;
    assign field_mag = mag_reg;

endmodule

`default_nettype wire

// ===== src/dsfp_assemble.sv =====
// ----------------------------------------------------------------------------
// dsfp_assemble
// End-of-string result: closes an open month name, applies trailing text,
// splits fixed-width digit strings and places the fields as month, day, year.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_assemble #(
    parameter int VALUE_BITS = 16
) (
    input  wire dsfp_pkg::scan_state_t                 state,
    input  wire logic [2:0][VALUE_BITS-1:0]            field_mag,
    input  wire logic [dsfp_pkg::ORDER_BITS-1:0]       order_first,
    input  wire logic [dsfp_pkg::ORDER_BITS-1:0]       order_second,
    input  wire logic [dsfp_pkg::ORDER_BITS-1:0]       order_third,
    output logic signed [dsfp_pkg::RESULT_BITS-1:0]    month_value,
    output logic signed [dsfp_pkg::RESULT_BITS-1:0]    day_value,
    output logic signed [dsfp_pkg::RESULT_BITS-1:0]    year_value
);
    import dsfp_pkg::*;

    localparam int WIDE_BITS = (VALUE_BITS > SPLIT_BITS) ? VALUE_BITS : SPLIT_BITS;
    localparam logic [WIDE_BITS-1:0] SAT_MAX = WIDE_BITS'({VALUE_BITS{1'b1}});

    logic [2:0][VALUE_BITS-1:0]   mag;
    logic [2:0]                   neg;
    logic [3:0]                   word_month;
    logic                         split_en;
    logic [7:0][3:0]              b;
    logic [7:0][3:0]              d;
    logic [2:0][SPLIT_BITS-1:0]   split_raw;
    logic [WIDE_BITS-1:0]         wide;
    logic [2:0][RESULT_BITS-1:0]  fv;
    logic [2:0][ORDER_BITS-1:0]   ord;
    logic [RESULT_BITS-1:0]       mon;
    logic [RESULT_BITS-1:0]       day;
    logic [RESULT_BITS-1:0]       yr;

    always_comb begin
        mag        = field_mag;
        neg        = state.field_name;
        word_month = month_number(state.name_prefix, state.prefix_count);

        if (state.phase == PH_NAME && state.field_index != FIELD_COUNT) begin
            mag[state.field_index] = VALUE_BITS'(word_month);
            neg[state.field_index] = (word_month != 4'd0);
        end
        if (state.trailing_text) begin
            mag[2] = '0;
            neg[2] = 1'b0;
        end

        b        = state.digits;
        d        = (state.string_length == LENGTH_PAD) ? {b[6:0], 4'd0} : b;
        split_en = state.all_digits && (state.string_length inside {[4'd5:4'd8]});

        case (state.string_length)
            4'd5: begin
                split_raw[0] = SPLIT_BITS'(b[0]);
                split_raw[1] = SPLIT_BITS'(dec2(b[1], b[2]));
                split_raw[2] = SPLIT_BITS'(dec2(b[3], b[4]));
            end
            4'd6: begin
                split_raw[0] = SPLIT_BITS'(dec2(b[0], b[1]));
                split_raw[1] = SPLIT_BITS'(dec2(b[2], b[3]));
                split_raw[2] = SPLIT_BITS'(dec2(b[4], b[5]));
            end
            default: begin
                if (order_first == ORD_YEAR) begin
                    split_raw[0] = dec4(d[0], d[1], d[2], d[3]);
                    split_raw[1] = SPLIT_BITS'(dec2(d[4], d[5]));
                    split_raw[2] = SPLIT_BITS'(dec2(d[6], d[7]));
                end else if (order_second == ORD_YEAR) begin
                    split_raw[0] = SPLIT_BITS'(dec2(d[0], d[1]));
                    split_raw[1] = dec4(d[2], d[3], d[4], d[5]);
                    split_raw[2] = SPLIT_BITS'(dec2(d[6], d[7]));
                end else begin
                    split_raw[0] = SPLIT_BITS'(dec2(d[0], d[1]));
                    split_raw[1] = SPLIT_BITS'(dec2(d[2], d[3]));
                    split_raw[2] = dec4(d[4], d[5], d[6], d[7]);
                end
            end
        endcase

        wide = '0;
        if (split_en) begin
            for (int k = 0; k < 3; k++) begin
                wide   = WIDE_BITS'(split_raw[k]);
                mag[k] = (wide > SAT_MAX) ? {VALUE_BITS{1'b1}} : wide[VALUE_BITS-1:0];
                neg[k] = 1'b0;
            end
        end

        for (int k = 0; k < 3; k++) begin
            fv[k] = neg[k] ? -RESULT_BITS'(mag[k][3:0]) : RESULT_BITS'(mag[k]);
        end

        ord[0] = order_first;
        ord[1] = order_second;
        ord[2] = order_third;
        mon    = '0;
        day    = '0;
        yr     = '0;
        if (neg[0]) begin
            mon = RESULT_BITS'(mag[0][3:0]);
            day = fv[1];
            yr  = fv[2];
        end else if (neg[1]) begin
            mon = RESULT_BITS'(mag[1][3:0]);
            day = fv[0];
            yr  = fv[2];
        end else begin
            for (int k = 0; k < 3; k++) begin
                case (ord[k])
                    ORD_YEAR:  yr  = fv[k];
                    ORD_MONTH: mon = fv[k];
                    ORD_DAY:   day = fv[k];
                    default:   ;
                endcase
            end
        end

        month_value = signed'(mon);
        day_value   = signed'(day);
        year_value  = signed'(yr);
    end

endmodule

`default_nettype wire

// ===== src/date_string_field_parser_unit.sv =====
// ----------------------------------------------------------------------------
// date_string_field_parser_unit
// Streaming date string parser: one byte per beat in, one month/day/year
// result per zero-terminated string out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one byte of a date string per beat (s_char_code); a zero byte
//   ends the string. Letters are case-blind. Non-zero bytes give no result.
//   m_ channel: one beat per terminated string carrying month, day and year
//   as 17-bit two's complement values.
//   APB port: order registers at 0x0, 0x4, 0x8 (first, second, third field
//   meaning; 1 year, 2 month, 3 day). Write them only while the unit is idle.
// Timing:
//   A byte is taken into an input register and scanned from there; a
//   terminating byte loads the output register at the edge at which it
//   leaves the input register, which raises m_valid. Sustained rate is one
//   byte per cycle while no zero byte waits there for the output register.
// Reset and stalls:
//   aresetn (synchronous, active low) clears the parse state and the order
//   registers to 2, 3, 1. While m_ready is low with a result pending, bytes
//   that end no string keep flowing; a zero byte waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module date_string_field_parser_unit #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [dsfp_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [dsfp_pkg::DATA_BITS-1:0]        pwdata,
    output logic      [dsfp_pkg::DATA_BITS-1:0]        prdata,
    output logic                                       pready,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [7:0]                            s_char_code,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [dsfp_pkg::RESULT_BITS-1:0]    m_month_value,
    output logic signed [dsfp_pkg::RESULT_BITS-1:0]    m_day_value,
    output logic signed [dsfp_pkg::RESULT_BITS-1:0]    m_year_value
);
    import dsfp_pkg::*;

    logic [ORDER_BITS-1:0]         order_first_reg;
    logic [ORDER_BITS-1:0]         order_second_reg;
    logic [ORDER_BITS-1:0]         order_third_reg;
    logic                          cfg_write;
    logic [1:0]                    cfg_sel;

    logic                          in_valid_reg;
    logic [7:0]                    in_char_reg;
    logic                          in_is_end;
    logic                          out_free;
    logic                          step;
    logic                          s_beat;

    logic                          out_valid_reg;
    logic signed [RESULT_BITS-1:0] month_reg;
    logic signed [RESULT_BITS-1:0] day_reg;
    logic signed [RESULT_BITS-1:0] year_reg;

    scan_state_t                   scan_state;
    logic [2:0][VALUE_BITS-1:0]    field_mag;
    logic signed [RESULT_BITS-1:0] month_next;
    logic signed [RESULT_BITS-1:0] day_next;
    logic signed [RESULT_BITS-1:0] year_next;

    // configuration
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_first_reg  <= ORDER_FIRST_RESET;
            order_second_reg <= ORDER_SECOND_RESET;
            order_third_reg  <= ORDER_THIRD_RESET;
        end else if (cfg_write) begin
            case (cfg_sel)
                REG_ORDER_FIRST:  order_first_reg  <= pwdata[ORDER_BITS-1:0];
                REG_ORDER_SECOND: order_second_reg <= pwdata[ORDER_BITS-1:0];
                REG_ORDER_THIRD:  order_third_reg  <= pwdata[ORDER_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_ORDER_FIRST:  prdata = DATA_BITS'(order_first_reg);
            REG_ORDER_SECOND: prdata = DATA_BITS'(order_second_reg);
            REG_ORDER_THIRD:  prdata = DATA_BITS'(order_third_reg);
            default:          prdata = '0;
        endcase
    end

    // handshake: a terminating byte advances only when the result register frees
    assign in_is_end = (in_char_reg == CH_END);
    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && (!in_is_end || out_free);
    assign s_ready   = !in_valid_reg || step;
    assign s_beat    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_beat) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_char_reg <= s_char_code;
        end
    end

    dsfp_scan #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (step && !in_is_end),
        .clear     (step && in_is_end),
        .char_code (in_char_reg),
        .state     (scan_state),
        .field_mag (field_mag)
    );

    dsfp_assemble #(
        .VALUE_BITS (VALUE_BITS)
    ) u_assemble (
        .state        (scan_state),
        .field_mag    (field_mag),
        .order_first  (order_first_reg),
        .order_second (order_second_reg),
        .order_third  (order_third_reg),
        .month_value  (month_next),
        .day_value    (day_next),
        .year_value   (year_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_is_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_is_end) begin
            month_reg <= month_next;
            day_reg   <= day_next;
            year_reg  <= year_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_month_value = month_reg;
    assign m_day_value   = day_reg;
    assign m_year_value  = year_reg;

endmodule

`default_nettype wire

// ===== sim/date_string_field_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// date_string_field_parser_unit_tb
// Streams date strings into the parser one byte per beat and checks every
// month/day/year result against a behavioural predictor. Directed strings
// cover month names in each position, fixed-width digit strings, stuck and
// trailing characters, saturation and unusual order codes. Random strings,
// mostly well-formed dates with random content, follow under several order
// settings and three handshake idling schemes.
// ----------------------------------------------------------------------------
module date_string_field_parser_unit_tb;
    import dsfp_pkg::*;

    localparam int     VALUE_BITS   = 16;
    localparam longint VALUE_MAX    = (longint'(1) << VALUE_BITS) - 1;
    localparam int     HALF_PERIOD  = 10;
    localparam longint RUN_LIMIT    = 4_000_000;
    localparam int     REPORT_LIMIT = 10;
    localparam int     CHUNK_BEATS  = 210;
    localparam logic [ORDER_BITS-1:0] ORD_NONE = 2'd0;

    typedef struct {
        logic signed [RESULT_BITS-1:0] month;
        logic signed [RESULT_BITS-1:0] day;
        logic signed [RESULT_BITS-1:0] year;
    } date_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [ADDR_BITS-1:0]          paddr       = '0;
    logic [DATA_BITS-1:0]          pwdata      = '0;
    logic [DATA_BITS-1:0]          prdata;
    logic                          pready;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_char_code = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic signed [RESULT_BITS-1:0] m_month_value;
    logic signed [RESULT_BITS-1:0] m_day_value;
    logic signed [RESULT_BITS-1:0] m_year_value;

    // parse state of the predictor
    longint                field_val [3];
    int                    field_no;
    phase_t                scan_phase;
    logic [14:0]           word_key;
    int                    word_len;
    logic [3:0]            digit_reg [8];
    int                    char_count;
    bit                    only_digits;
    bit                    extra_text;
    logic [ORDER_BITS-1:0] ord_cfg [3];

    date_t      expected_dates [$];
    logic [7:0] draft [$];
    int         mismatches   = 0;
    int         beats_sent   = 0;
    int         send_gap_pct = 29;
    int         recv_gap_pct = 46;
    string      word_set     = "januaryfebmrchpilgstovd";
    string      month_full [12] = '{"january", "february", "march", "april", "may", "june",
                                    "july", "august", "september", "october", "november",
                                    "december"};

    date_string_field_parser_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_month_value (m_month_value),
        .m_day_value   (m_day_value),
        .m_year_value  (m_year_value)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void clear_scan();
        for (int i = 0; i < 3; i++) field_val[i] = 0;
        for (int i = 0; i < 8; i++) digit_reg[i] = '0;
        field_no    = 0;
        scan_phase  = PH_LEAD;
        word_key    = '0;
        word_len    = 0;
        char_count  = 0;
        only_digits = 1'b1;
        extra_text  = 1'b0;
    endfunction

    function automatic longint saturate(input longint v);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

    function automatic bit month_letter(input logic [7:0] c);
        for (int i = 0; i < word_set.len(); i++) begin
            if (word_set[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic longint month_code();
        string      names;
        logic [7:0] a, b, c;
        names = "janfebmaraprmayjunjulaugsepoctnovdec";
        if (word_len != 3) return 0;
        for (int i = 0; i < 12; i++) begin
            a = names[3*i];
            b = names[3*i+1];
            c = names[3*i+2];
            if ({a[4:0], b[4:0], c[4:0]} == word_key) return -(i + 1);
        end
        return 0;
    endfunction

    function automatic void close_field(input longint v);
        field_val[(field_no > 2) ? 2 : field_no] = v;
        field_no++;
        scan_phase = (field_no >= 3) ? PH_DONE : PH_LEAD;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        bit is_digit;
        int k;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        for (int guard = 0; guard < 8; guard++) begin
            k = (field_no > 2) ? 2 : field_no;
            case (scan_phase)
                PH_LEAD: begin
                    if (c == CH_SPACE) return;
                    scan_phase = PH_POST;
                    if (k > 0 && (c == CH_DASH || c == CH_SLASH || c == CH_COMMA)) return;
                end
                PH_POST: begin
                    if (c == CH_SPACE) return;
                    if (is_digit) begin
                        field_val[k] = c - CH_ZERO;
                        scan_phase   = PH_NUM;
                        return;
                    end
                    if (month_letter(c)) begin
                        word_key   = 15'(c[4:0]);
                        word_len   = 1;
                        scan_phase = PH_NAME;
                        return;
                    end
                    close_field(0);
                end
                PH_NUM: begin
                    if (is_digit) begin
                        field_val[k] = saturate(field_val[k] * 10 + longint'(c - CH_ZERO));
                        return;
                    end
                    close_field(field_val[k]);
                end
                PH_NAME: begin
                    if (month_letter(c)) begin
                        if (word_len < 3) begin
                            word_key = {word_key[9:0], c[4:0]};
                            word_len++;
                        end
                        return;
                    end
                    close_field(month_code());
                end
                default: begin
                    extra_text = 1'b1;
                    return;
                end
            endcase
        end
    endfunction

    function automatic void split_fixed();
        int d [8];
        int width [3];
        int pos;
        for (int i = 0; i < 8; i++) d[i] = digit_reg[i];
        if (char_count == 7) begin
            for (int i = 7; i > 0; i--) d[i] = d[i - 1];
            d[0] = 0;
        end
        if (char_count == 5) width = '{1, 2, 2};
        else if (char_count == 6) width = '{2, 2, 2};
        else if (ord_cfg[REG_ORDER_FIRST] == ORD_YEAR) width = '{4, 2, 2};
        else if (ord_cfg[REG_ORDER_SECOND] == ORD_YEAR) width = '{2, 4, 2};
        else width = '{2, 2, 4};
        pos = 0;
        for (int f = 0; f < 3; f++) begin
            field_val[f] = 0;
            for (int i = 0; i < width[f]; i++) field_val[f] = field_val[f] * 10 + d[pos + i];
            pos += width[f];
        end
    endfunction

    function automatic void take_char(input logic [7:0] raw);
        logic [7:0] c;
        longint     mon, day, yr;
        date_t      want;
        c = raw;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c | CASE_BIT;
        if (c != CH_END) begin
            if (char_count < LENGTH_MAX) char_count++;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (char_count <= 8) digit_reg[char_count - 1] = 4'(c - CH_ZERO);
            end else begin
                only_digits = 1'b0;
            end
            scan_char(c);
            return;
        end
        if (field_no < 3 && scan_phase == PH_NAME) field_val[field_no] = month_code();
        if (extra_text) field_val[2] = 0;
        if (only_digits && char_count >= 5 && char_count <= 8) split_fixed();
        mon = 0;
        day = 0;
        yr  = 0;
        if (field_val[0] < 0) begin
            mon = -field_val[0];
            day = field_val[1];
            yr  = field_val[2];
        end else if (field_val[1] < 0) begin
            mon = -field_val[1];
            day = field_val[0];
            yr  = field_val[2];
        end else begin
            for (int i = 0; i < 3; i++) begin
                case (ord_cfg[i])
                    ORD_YEAR:  yr  = field_val[i];
                    ORD_MONTH: mon = field_val[i];
                    ORD_DAY:   day = field_val[i];
                    default:   ;
                endcase
            end
        end
        want.month = mon[RESULT_BITS-1:0];
        want.day   = day[RESULT_BITS-1:0];
        want.year  = yr[RESULT_BITS-1:0];
        expected_dates.push_back(want);
        clear_scan();
    endfunction

    function automatic void check_date();
        date_t got, want;
        got.month = m_month_value;
        got.day   = m_day_value;
        got.year  = m_year_value;
        if (expected_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected result m=%0d d=%0d y=%0d",
                         $time, got.month, got.day, got.year);
            return;
        end
        want = expected_dates.pop_front();
        if (got.month !== want.month || got.day !== want.day || got.year !== want.year) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: expected m=%0d d=%0d y=%0d, got m=%0d d=%0d y=%0d", $time,
                         want.month, want.day, want.year, got.month, got.day, got.year);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_date();
            if (s_valid && s_ready) take_char(s_char_code);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [1:0] index, input logic [ORDER_BITS-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({index, 2'b00});
        pwdata  <= DATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ord_cfg[index] = value;
    endtask

    // drop valid and hold until every result is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_order(input logic [ORDER_BITS-1:0] f, s, t);
        wait_idle();
        write_register(REG_ORDER_FIRST, f);
        write_register(REG_ORDER_SECOND, s);
        write_register(REG_ORDER_THIRD, t);
    endtask

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_draft();
        foreach (draft[i]) send_char(draft[i]);
        send_char(CH_END);
    endtask

    task automatic send_text(input string txt);
        draft.delete();
        for (int i = 0; i < txt.len(); i++) draft.push_back(txt[i]);
        send_draft();
    endtask

    // ------------------------------------------------------------------------
    // random date strings
    // ------------------------------------------------------------------------
    function automatic void add_letter(input logic [7:0] c);
        draft.push_back(($urandom_range(99) < 30) ? (c ^ CASE_BIT) : c);
    endfunction

    function automatic void add_spaces(input int most);
        repeat ($urandom_range(most)) draft.push_back(CH_SPACE);
    endfunction

    function automatic void add_number();
        int count;
        count = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        repeat (count) draft.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void add_word();
        string w;
        int    keep;
        w    = month_full[$urandom_range(11)];
        keep = 0;
        case ($urandom_range(3))
            0, 1:    keep = $urandom_range(3, w.len());
            2:       keep = $urandom_range(1, 2);
            default: w = word_set;
        endcase
        if (keep == 0) begin
            repeat ($urandom_range(1, 6)) add_letter(w[$urandom_range(w.len() - 1)]);
        end else begin
            for (int i = 0; i < keep; i++) add_letter(w[i]);
        end
    endfunction

    function automatic void add_field();
        if ($urandom_range(99) < 35) add_word();
        else add_number();
    endfunction

    function automatic void add_gap();
        string marks;
        marks = "-/,";
        if ($urandom_range(99) < 60) begin
            add_spaces(1);
            draft.push_back(marks[$urandom_range(2)]);
            add_spaces(1);
        end else begin
            repeat ($urandom_range(1, 2)) draft.push_back(CH_SPACE);
        end
    endfunction

    function automatic void compose_date(input int fields);
        add_spaces(1);
        add_field();
        repeat (fields - 1) begin
            add_gap();
            add_field();
        end
    endfunction

    function automatic void make_date_text();
        int kind;
        int count;
        draft.delete();
        kind = $urandom_range(99);
        if (kind < 45) begin
            compose_date(3);
            if ($urandom_range(9) == 0) begin
                add_gap();
                add_field();
            end
        end else if (kind < 60) begin
            count = ($urandom_range(4) == 0) ? $urandom_range(1, 16) : $urandom_range(5, 8);
            repeat (count) draft.push_back(CH_ZERO + 8'($urandom_range(9)));
        end else if (kind < 70) begin
            compose_date($urandom_range(1, 2));
            if ($urandom_range(1) == 1) add_gap();
        end else if (kind < 85) begin
            compose_date(3);
            draft.insert($urandom_range(draft.size()), 8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(1, 14)) draft.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    task automatic pick_order();
        logic [ORDER_BITS-1:0] perm [3];
        logic [ORDER_BITS-1:0] t;
        int                    j;
        if ($urandom_range(99) < 70) begin
            perm = '{ORD_YEAR, ORD_MONTH, ORD_DAY};
            for (int i = 2; i > 0; i--) begin
                j       = $urandom_range(i);
                t       = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
        end else begin
            for (int i = 0; i < 3; i++) perm[i] = ORDER_BITS'($urandom_range(3));
        end
        set_order(perm[0], perm[1], perm[2]);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_month_names();
        send_text("Mar 5 21");
        send_text("5-DEC-1999");
        send_text("1/2/sep");
        send_text("january 1");
        send_text("ju 4 foo");
    endtask

    task automatic test_fixed_width();
        send_text("12345");
        send_text("123456");
        send_text("1234567");
        send_text("03152024");
        set_order(ORD_YEAR, ORD_MONTH, ORD_DAY);
        send_text("20240315");
        send_text("1234567");
        set_order(ORD_DAY, ORD_YEAR, ORD_MONTH);
        send_text("15202403");
    endtask

    task automatic test_odd_text();
        set_order(ORD_MONTH, ORD_DAY, ORD_YEAR);
        send_text("");
        send_text("70000 1 2");
        send_text("1 2 3 x");
        send_text("#1 2");
        send_text("12345678901234567");
        draft = {8'hFF, 8'h80, CH_SPACE, CH_NINE};
        send_draft();
    endtask

    task automatic test_order_codes();
        set_order(ORD_NONE, ORD_NONE, ORD_NONE);
        send_text("1 2 3");
        set_order(ORD_DAY, ORD_DAY, ORD_DAY);
        send_text("4 5 6");
    endtask

    task automatic test_random_dates();
        int stop_at;
        for (int mode = 0; mode < 3; mode++) begin
            send_gap_pct = (mode == 0) ? 29 : (mode == 1) ? 46 : 0;
            recv_gap_pct = (mode == 0) ? 46 : (mode == 1) ? 29 : 0;
            for (int chunk = 0; chunk < 3; chunk++) begin
                pick_order();
                stop_at = beats_sent + CHUNK_BEATS;
                while (beats_sent < stop_at) begin
                    make_date_text();
                    send_draft();
                end
            end
        end
    endtask

    initial begin
        ord_cfg = '{ORDER_FIRST_RESET, ORDER_SECOND_RESET, ORDER_THIRD_RESET};
        clear_scan();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_month_names();
        test_fixed_width();
        test_odd_text();
        test_order_codes();
        test_random_dates();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_dates.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dsfp_pkg.sv
src/dsfp_scan.sv
src/dsfp_assemble.sv
src/date_string_field_parser_unit.sv
sim/date_string_field_parser_unit_tb.sv
